>>> rtl/tca_pkg.sv
// tca_pkg: shared types, codes and constants of the trace channel allocator.
// No dependencies; imported by trace_channel_allocator.
`timescale 1ns / 1ps

package tca_pkg;

  localparam int MASTER_W  = 8;
  localparam int CHAN_W    = 7;
  localparam int BYTE_W    = 8;
  localparam int MAP_DEPTH = 16;
  localparam int ADDR_W    = 4;
  localparam int BIT_W     = 3;
  localparam int POOL_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam int POOL_BYTES_DEF = 16;

  localparam logic [BYTE_W-1:0] BYTE_FULL = 8'hff;
  localparam logic [BYTE_W-1:0] BIT_MSB   = 8'h80;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [POOL_W-1:0] POOL_A   = 2'd0;
  localparam logic [POOL_W-1:0] POOL_B   = 2'd1;
  localparam logic [POOL_W-1:0] POOL_C   = 2'd2;
  localparam logic [POOL_W-1:0] POOL_BAD = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_A_MASTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_B_MASTER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_C_MASTER = 2'd2;

  localparam logic [MASTER_W-1:0] POOL_A_MASTER_RST = 8'd0;
  localparam logic [MASTER_W-1:0] POOL_B_MASTER_RST = 8'd1;
  localparam logic [MASTER_W-1:0] POOL_C_MASTER_RST = 8'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FREE,
    ST_RESP
  } state_t;

  // position of the first clear bit, counted from the MSB
  function automatic logic [BIT_W-1:0] first_clear(input logic [BYTE_W-1:0] b);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      if (!b[i]) begin
        pos = BIT_W'(BYTE_W - 1 - i);
      end
    end
    return pos;
  endfunction

endpackage

>>> rtl/trace_channel_allocator.sv
// trace_channel_allocator: first-fit channel allocator over three bitmap pools.
// Path, accepting edge to out_valid: free ST_FREE then ST_RESP, invalid pool ST_RESP alone,
// allocate ST_SCAN per byte scanned (1..pool bytes) then ST_RESP, held while the previous response waits on out_ready.
// Throughput: one request at a time; the byte scan (one map byte per cycle) sets the rate.
// A new request is taken while the previous response waits in the output register.
// Reset (rst_n low, synchronous): all maps cleared, masters 0/1/2, no response pending.
`timescale 1ns / 1ps

module trace_channel_allocator #(
  parameter int POOL_A_BYTES = tca_pkg::POOL_BYTES_DEF,
  parameter int POOL_B_BYTES = tca_pkg::POOL_BYTES_DEF,
  parameter int POOL_C_BYTES = tca_pkg::POOL_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_func,
  input  logic [tca_pkg::POOL_W-1:0]     in_pool,
  input  logic [tca_pkg::MASTER_W-1:0]   in_master,
  input  logic [tca_pkg::CHAN_W-1:0]     in_channel,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_ok,
  output logic [tca_pkg::MASTER_W-1:0]   out_master,
  output logic [tca_pkg::CHAN_W-1:0]     out_channel,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tca_pkg::MASTER_W-1:0]   cfg_data
);
  import tca_pkg::*;

  localparam logic [ADDR_W-1:0] A_LAST = ADDR_W'(POOL_A_BYTES - 1);
  localparam logic [ADDR_W-1:0] B_LAST = ADDR_W'(POOL_B_BYTES - 1);
  localparam logic [ADDR_W-1:0] C_LAST = ADDR_W'(POOL_C_BYTES - 1);

  state_t state_r, state_nxt;

  logic [MASTER_W-1:0] master_a_r, master_b_r, master_c_r;
  logic [BYTE_W-1:0]   map_a_r [MAP_DEPTH];
  logic [BYTE_W-1:0]   map_b_r [MAP_DEPTH];
  logic [BYTE_W-1:0]   map_c_r [MAP_DEPTH];

  logic [POOL_W-1:0]   pool_r, pool_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [BIT_W-1:0]    bit_r, bit_nxt;

  logic                res_ok_r, res_ok_nxt;
  logic [MASTER_W-1:0] res_master_r, res_master_nxt;
  logic [CHAN_W-1:0]   res_chan_r, res_chan_nxt;
  logic                res_load;

  logic                out_valid_r;
  logic                out_ok_r;
  logic [MASTER_W-1:0] out_master_r;
  logic [CHAN_W-1:0]   out_chan_r;
  logic                out_load;

  logic                accept;
  logic [POOL_W-1:0]   free_pool;
  logic [BYTE_W-1:0]   rd_byte;
  logic [ADDR_W-1:0]   last_sel;
  logic [MASTER_W-1:0] master_sel;
  logic [BIT_W-1:0]    hit_pos;
  logic                hit;
  logic                wr_en;
  logic [BYTE_W-1:0]   wr_byte;

  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign free_pool = (in_master == master_a_r) ? POOL_A :
                     (in_master == master_b_r) ? POOL_B : POOL_C;

  always_comb begin
    case (pool_r)
      POOL_A: begin
        rd_byte    = map_a_r[addr_r];
        last_sel   = A_LAST;
        master_sel = master_a_r;
      end
      POOL_B: begin
        rd_byte    = map_b_r[addr_r];
        last_sel   = B_LAST;
        master_sel = master_b_r;
      end
      default: begin
        rd_byte    = map_c_r[addr_r];
        last_sel   = C_LAST;
        master_sel = master_c_r;
      end
    endcase
  end

  assign hit     = (rd_byte != BYTE_FULL);
  assign hit_pos = first_clear(rd_byte);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_FREE) begin
            state_nxt = ST_FREE;
          end else if (in_pool == POOL_BAD) begin
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit || addr_r == last_sel) begin
          state_nxt = ST_RESP;
        end
      end
      ST_FREE: state_nxt = ST_RESP;
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    in_ready       = 1'b0;
    pool_nxt       = pool_r;
    addr_nxt       = addr_r;
    bit_nxt        = bit_r;
    wr_en          = 1'b0;
    wr_byte        = rd_byte;
    res_load       = 1'b0;
    res_ok_nxt     = 1'b0;
    res_master_nxt = '0;
    res_chan_nxt   = '0;
    out_load       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          if (in_func == FUNC_FREE) begin
            pool_nxt = free_pool;
            addr_nxt = in_channel[CHAN_W-1:BIT_W];
            bit_nxt  = in_channel[BIT_W-1:0];
          end else if (in_pool == POOL_BAD) begin
            res_load = 1'b1;
          end else begin
            pool_nxt = in_pool;
            addr_nxt = '0;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          wr_en          = 1'b1;
          wr_byte        = rd_byte | (BIT_MSB >> hit_pos);
          res_load       = 1'b1;
          res_ok_nxt     = 1'b1;
          res_master_nxt = master_sel;
          res_chan_nxt   = {addr_r, hit_pos};
        end else if (addr_r == last_sel) begin
          res_load = 1'b1;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_FREE: begin
        wr_en      = (addr_r <= last_sel);
        wr_byte    = rd_byte & ~(BIT_MSB >> bit_r);
        res_load   = 1'b1;
        res_ok_nxt = 1'b1;
      end
      ST_RESP: begin
        out_load = !out_valid_r || out_ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pool_r      <= POOL_A;
      addr_r      <= '0;
      bit_r       <= '0;
      master_a_r  <= POOL_A_MASTER_RST;
      master_b_r  <= POOL_B_MASTER_RST;
      master_c_r  <= POOL_C_MASTER_RST;
      for (int i = 0; i < MAP_DEPTH; i++) begin
        map_a_r[i] <= '0;
        map_b_r[i] <= '0;
        map_c_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      pool_r  <= pool_nxt;
      addr_r  <= addr_nxt;
      bit_r   <= bit_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_POOL_A_MASTER: master_a_r <= cfg_data;
          CFG_POOL_B_MASTER: master_b_r <= cfg_data;
          CFG_POOL_C_MASTER: master_c_r <= cfg_data;
          default: ;
        endcase
      end
      if (wr_en) begin
        case (pool_r)
          POOL_A:  map_a_r[addr_r] <= wr_byte;
          POOL_B:  map_b_r[addr_r] <= wr_byte;
          default: map_c_r[addr_r] <= wr_byte;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_ok_r     <= res_ok_nxt;
      res_master_r <= res_master_nxt;
      res_chan_r   <= res_chan_nxt;
    end
    if (out_load) begin
      out_ok_r     <= res_ok_r;
      out_master_r <= res_master_r;
      out_chan_r   <= res_chan_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_ok      = out_ok_r;
  assign out_master  = out_master_r;
  assign out_channel = out_chan_r;

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_master == '0 && out_channel == '0)
    else $error("failed request carries a nonzero master or channel");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> addr_r <= last_sel && pool_r != POOL_BAD)
    else $error("scan address beyond the pool");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != ST_IDLE)
    else $error("request accepted without leaving idle");

  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> state_r == ST_SCAN || state_r == ST_FREE)
    else $error("map written outside scan or free");

endmodule

>>> tb/trace_channel_allocator_tb.sv
// trace_channel_allocator_tb: self-checking bench for the trace channel allocator.
// Drives allocate and free requests against a first-fit bitmap predictor; needs tca_pkg
// and trace_channel_allocator only.
`timescale 1ns / 1ps

module trace_channel_allocator_tb;
  import tca_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 6;
  localparam int REQUEST_TARGET = 700;
  localparam int FILL_REQUESTS  = 131;
  localparam int DRAIN_CYCLES   = 40;
  localparam int QUIET_LIMIT    = 4000;
  localparam int POOL_COUNT     = 3;
  localparam int POOL_BYTES     = POOL_BYTES_DEF;
  localparam int CHAN_COUNT     = 1 << CHAN_W;

  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 2'd3;
  localparam logic RESP_FAIL = 1'b0;
  localparam logic RESP_OK   = 1'b1;
  localparam logic ROW_MODEL = 1'b0;
  localparam logic ROW_TYPED = 1'b1;

  typedef struct packed {
    logic                func;
    logic [POOL_W-1:0]   pool;
    logic [MASTER_W-1:0] master;
    logic [CHAN_W-1:0]   channel;
  } chan_req_t;

  typedef struct packed {
    logic                ok;
    logic [MASTER_W-1:0] master;
    logic [CHAN_W-1:0]   channel;
  } chan_resp_t;

  typedef struct packed {
    chan_req_t  req;
    logic       kind;
    chan_resp_t resp;
  } dir_row_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_CHOKED
  } rx_mode_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 in_ready;
  logic                 in_func    = FUNC_ALLOC;
  logic [POOL_W-1:0]    in_pool    = POOL_A;
  logic [MASTER_W-1:0]  in_master  = '0;
  logic [CHAN_W-1:0]    in_channel = '0;
  logic                 out_valid;
  logic                 out_ready  = 1'b0;
  logic                 out_ok;
  logic [MASTER_W-1:0]  out_master;
  logic [CHAN_W-1:0]    out_channel;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = CFG_POOL_A_MASTER;
  logic [MASTER_W-1:0]  cfg_data   = '0;

  // predictor state
  logic [BYTE_W-1:0]   chan_map [POOL_COUNT][MAP_DEPTH];
  logic [MASTER_W-1:0] pool_master [POOL_COUNT];

  chan_resp_t pending_responses [$];
  chan_resp_t expected_resp;
  chan_resp_t actual_resp;
  int         errors        = 0;
  int         requests_sent = 0;
  int         burst_left    = 0;
  int         quiet_cycles  = 0;
  rx_mode_t   rx_mode       = RX_OPEN;
  int         rx_left       = 0;

  dir_row_t directed_rows [16] = '{
    {FUNC_ALLOC, POOL_A,   8'd0,   7'd0,   ROW_TYPED, RESP_OK,   8'd0, 7'd0},
    {FUNC_ALLOC, POOL_A,   8'd255, 7'd127, ROW_TYPED, RESP_OK,   8'd0, 7'd1},
    {FUNC_ALLOC, POOL_B,   8'd0,   7'd0,   ROW_TYPED, RESP_OK,   8'd1, 7'd0},
    {FUNC_ALLOC, POOL_C,   8'd0,   7'd0,   ROW_TYPED, RESP_OK,   8'd2, 7'd0},
    {FUNC_ALLOC, POOL_BAD, 8'd255, 7'd127, ROW_TYPED, RESP_FAIL, 8'd0, 7'd0},
    {FUNC_FREE,  POOL_BAD, 8'd0,   7'd0,   ROW_TYPED, RESP_OK,   8'd0, 7'd0},
    {FUNC_ALLOC, POOL_A,   8'd0,   7'd0,   ROW_MODEL, RESP_FAIL, 8'd0, 7'd0},
    {FUNC_FREE,  POOL_A,   8'd255, 7'd127, ROW_TYPED, RESP_OK,   8'd0, 7'd0},
    {FUNC_FREE,  POOL_B,   8'd2,   7'd0,   ROW_TYPED, RESP_OK,   8'd0, 7'd0},
    {FUNC_ALLOC, POOL_C,   8'd0,   7'd0,   ROW_MODEL, RESP_FAIL, 8'd0, 7'd0},
    {FUNC_FREE,  POOL_C,   8'd1,   7'd127, ROW_TYPED, RESP_OK,   8'd0, 7'd0},
    {FUNC_FREE,  POOL_A,   8'd1,   7'd0,   ROW_TYPED, RESP_OK,   8'd0, 7'd0},
    {FUNC_ALLOC, POOL_B,   8'd0,   7'd0,   ROW_MODEL, RESP_FAIL, 8'd0, 7'd0},
    {FUNC_FREE,  POOL_A,   8'd0,   7'd1,   ROW_TYPED, RESP_OK,   8'd0, 7'd0},
    {FUNC_ALLOC, POOL_A,   8'd170, 7'd85,  ROW_MODEL, RESP_FAIL, 8'd0, 7'd0},
    {FUNC_ALLOC, POOL_A,   8'd85,  7'd42,  ROW_MODEL, RESP_FAIL, 8'd0, 7'd0}
  };

  trace_channel_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_func    (in_func),
    .in_pool    (in_pool),
    .in_master  (in_master),
    .in_channel (in_channel),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_ok     (out_ok),
    .out_master (out_master),
    .out_channel(out_channel),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  function automatic chan_resp_t predict_channel_response(input chan_req_t r);
    chan_resp_t resp;
    int         p;
    int         i;
    int         sel;
    int         b;
    resp = '0;
    if (r.func == FUNC_ALLOC) begin
      if (r.pool != POOL_BAD) begin
        p   = int'(r.pool);
        sel = -1;
        for (i = POOL_BYTES - 1; i >= 0; i--) begin
          if (chan_map[p][i] != BYTE_FULL) sel = i;
        end
        if (sel >= 0) begin
          b = -1;
          for (i = 0; i < BYTE_W; i++) begin
            if (b < 0 && !chan_map[p][sel][BYTE_W-1-i]) b = i;
          end
          chan_map[p][sel][BYTE_W-1-b] = 1'b1;
          resp.ok      = RESP_OK;
          resp.master  = pool_master[p];
          resp.channel = CHAN_W'((sel << BIT_W) + b);
        end
      end
    end else begin
      if (r.master == pool_master[0]) p = 0;
      else if (r.master == pool_master[1]) p = 1;
      else p = 2;
      i = int'(r.channel >> BIT_W);
      if (i < POOL_BYTES) chan_map[p][i][BYTE_W-1-int'(r.channel[BIT_W-1:0])] = 1'b0;
      resp.ok = RESP_OK;
    end
    return resp;
  endfunction

  task automatic send_request(input chan_req_t r, input logic kind, input chan_resp_t typed_resp);
    chan_resp_t predicted;
    in_valid   <= 1'b1;
    in_func    <= r.func;
    in_pool    <= r.pool;
    in_master  <= r.master;
    in_channel <= r.channel;
    do @(posedge clk); while (!in_ready);
    predicted = predict_channel_response(r);
    pending_responses.push_back(kind == ROW_TYPED ? typed_resp : predicted);
    requests_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_responses.size() != 0);
    burst_left = $urandom_range(1, 8);
  endtask

  // hold cfg_valid across back-to-back writes, drop it once at the end
  task automatic program_masters(input logic [MASTER_W-1:0] ma, input logic [MASTER_W-1:0] mb,
                                 input logic [MASTER_W-1:0] mc, input bit add_reserved);
    logic [MASTER_W-1:0]  vals [4];
    logic [CFG_IDX_W-1:0] idxs [4];
    int                   j;
    vals[0] = ma;
    vals[1] = mb;
    vals[2] = mc;
    vals[3] = MASTER_W'($urandom_range(0, 255));
    idxs[0] = CFG_POOL_A_MASTER;
    idxs[1] = CFG_POOL_B_MASTER;
    idxs[2] = CFG_POOL_C_MASTER;
    idxs[3] = CFG_RESERVED;
    for (j = 0; j < (add_reserved ? 4 : 3); j++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[j];
      cfg_data  <= vals[j];
      do @(posedge clk); while (!cfg_ready);
      if (idxs[j] != CFG_RESERVED) pool_master[idxs[j]] = vals[j];
    end
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 2));
        rx_left <= $urandom_range(10, 60);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
        default:   out_ready <= ($urandom_range(0, 3) == 0);
      endcase
      if (out_valid && out_ready) begin
        actual_resp = '{ok: out_ok, master: out_master, channel: out_channel};
        if (pending_responses.size() == 0) begin
          errors++;
          $display("%0t: unexpected response ok=%0d master=%0d channel=%0d",
                   $time, out_ok, out_master, out_channel);
        end else begin
          expected_resp = pending_responses.pop_front();
          if (actual_resp.ok !== expected_resp.ok || actual_resp.master !== expected_resp.master ||
              actual_resp.channel !== expected_resp.channel) begin
            errors++;
            $display("%0t: mismatch expected ok=%0d master=%0d channel=%0d, actual ok=%0d master=%0d channel=%0d",
                     $time, expected_resp.ok, expected_resp.master, expected_resp.channel,
                     actual_resp.ok, actual_resp.master, actual_resp.channel);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    chan_req_t            r;
    int                   p;
    int                   k;
    int                   n;
    int                   start;
    int                   phase;
    bit                   found;
    logic [CHAN_W-1:0]    busy;
    logic [MASTER_W-1:0]  ma;
    logic [MASTER_W-1:0]  mb;
    logic [MASTER_W-1:0]  mc;
    bit                   add_reserved;

    for (p = 0; p < POOL_COUNT; p++) begin
      for (k = 0; k < MAP_DEPTH; k++) chan_map[p][k] = '0;
    end
    pool_master[0] = POOL_A_MASTER_RST;
    pool_master[1] = POOL_B_MASTER_RST;
    pool_master[2] = POOL_C_MASTER_RST;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    burst_left = $urandom_range(1, 8);

    foreach (directed_rows[k]) begin
      send_request(directed_rows[k].req, directed_rows[k].kind, directed_rows[k].resp);
    end
    settle_idle();

    // fill one pool to the brim, overrun it, then free and take back one channel
    program_masters(8'd255, 8'd0, 8'd128, 1'b0);
    p = $urandom_range(0, POOL_COUNT - 1);
    for (n = 0; n < FILL_REQUESTS; n++) begin
      r = '{func: FUNC_ALLOC, pool: POOL_W'(p), master: MASTER_W'($urandom_range(0, 255)),
            channel: CHAN_W'($urandom_range(0, CHAN_COUNT - 1))};
      send_request(r, ROW_MODEL, '0);
    end
    r = '{func: FUNC_FREE, pool: POOL_W'($urandom_range(0, 3)), master: pool_master[p],
          channel: CHAN_W'($urandom_range(0, CHAN_COUNT - 1))};
    send_request(r, ROW_MODEL, '0);
    r.func = FUNC_ALLOC;
    r.pool = POOL_W'(p);
    send_request(r, ROW_MODEL, '0);

    phase = 0;
    while (requests_sent < REQUEST_TARGET) begin
      settle_idle();
      add_reserved = 1'b0;
      case (phase % 6)
        0: begin ma = 8'd255; mb = 8'd254; mc = 8'd253; end
        1: begin ma = 8'd9;   mb = 8'd9;   mc = 8'd40;  end
        2: begin ma = 8'd0;   mb = 8'd77;  mc = 8'd77;  end
        3: begin ma = 8'd200; mb = 8'd200; mc = 8'd200; end
        4: begin
          ma = MASTER_W'($urandom_range(0, 255));
          mb = MASTER_W'($urandom_range(0, 255));
          mc = MASTER_W'($urandom_range(0, 255));
          add_reserved = 1'b1;
        end
        default: begin ma = POOL_A_MASTER_RST; mb = POOL_B_MASTER_RST; mc = POOL_C_MASTER_RST; end
      endcase
      program_masters(ma, mb, mc, add_reserved);

      repeat ($urandom_range(40, 90)) begin
        k = $urandom_range(0, 99);
        r = '{func: FUNC_ALLOC, pool: POOL_W'($urandom_range(0, 2)),
              master: MASTER_W'($urandom_range(0, 255)),
              channel: CHAN_W'($urandom_range(0, CHAN_COUNT - 1))};
        if (k < 55) begin
          r.func = FUNC_ALLOC;
        end else if (k < 80) begin
          // pick a channel that is taken in a random pool, if any, and free it by that pool's master
          r.func = FUNC_FREE;
          p      = $urandom_range(0, POOL_COUNT - 1);
          start  = $urandom_range(0, CHAN_COUNT - 1);
          found  = 1'b0;
          for (n = 0; n < CHAN_COUNT; n++) begin
            busy = CHAN_W'(start + n);
            if (!found && chan_map[p][busy >> BIT_W][BYTE_W-1-busy[BIT_W-1:0]]) begin
              found     = 1'b1;
              r.channel = busy;
            end
          end
          r.master = pool_master[p];
        end else if (k < 90) begin
          r.func = FUNC_FREE;
        end else if (k < 95) begin
          r.pool = POOL_BAD;
        end else begin
          r.func   = FUNC_FREE;
          r.master = pool_master[$urandom_range(0, POOL_COUNT - 1)];
        end
        send_request(r, ROW_MODEL, '0);
      end
      phase++;
    end

    settle_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
